// ----- hdl/masked_gaussian_height_smoother_macros.svh -----
// Assertion macros used by the smoother design file.
`ifndef MASKED_GAUSSIAN_HEIGHT_SMOOTHER_MACROS_SVH
`define MASKED_GAUSSIAN_HEIGHT_SMOOTHER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define MGS_CHECK_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define MGS_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/mgs_pkg.sv -----
package mgs_pkg;

   // Tile geometry
   localparam int GRID_SIDE  = 33;
   localparam int TILE_COUNT = GRID_SIDE * GRID_SIDE;
   localparam int RING_DEPTH = 2 * GRID_SIDE + 3;

   localparam int HEIGHT_W = 24;
   localparam int COORD_W  = $clog2(GRID_SIDE);
   localparam int POS_W    = $clog2(TILE_COUNT);
   localparam int RA_W     = $clog2(RING_DEPTH);
   localparam int ENTRY_W  = HEIGHT_W + 1;

   // Weighted sum: nine heights, weights totaling 16
   localparam int SUM_W   = HEIGHT_W + 4;
   localparam int WSUM_W  = 5;
   localparam int RECIP_W = 31;
   localparam int RECIP_SHIFT = 32;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam int QUOT_W  = HEIGHT_W + 1;

   // Neighborhood taps, row-major from the upper left corner
   localparam int TAP_COUNT = 9;
   localparam int TAP_W     = 4;
   localparam logic [TAP_W-1:0] TAP_FIRST = TAP_W'(0);
   localparam logic [TAP_W-1:0] TAP_LAST  = TAP_W'(TAP_COUNT - 1);

   typedef logic signed [HEIGHT_W-1:0] height_type;
   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic [WSUM_W-1:0]          wsum_type;

   typedef struct packed {
      logic     start;
      sum_type  sum;
      wsum_type wsum;
   } div_req_type;

   typedef struct packed {
      logic       valid;
      height_type quot;
   } div_rsp_type;

   // Ring offset of a tap from the center, modulo the ring depth
   function automatic logic [RA_W-1:0] tap_offset(input logic [TAP_W-1:0] k);
      logic [RA_W-1:0] off;
      unique case (k)
         4'd0:    off = RA_W'(GRID_SIDE + 2);
         4'd1:    off = RA_W'(GRID_SIDE + 3);
         4'd2:    off = RA_W'(GRID_SIDE + 4);
         4'd3:    off = RA_W'(2 * GRID_SIDE + 2);
         4'd4:    off = RA_W'(0);
         4'd5:    off = RA_W'(1);
         4'd6:    off = RA_W'(GRID_SIDE - 1);
         4'd7:    off = RA_W'(GRID_SIDE);
         4'd8:    off = RA_W'(GRID_SIDE + 1);
         default: off = RA_W'(0);
      endcase
      return off;
   endfunction

   // Log2 of the tap weight: corner 1, edge 2, center 4
   function automatic logic [1:0] tap_shift(input logic [TAP_W-1:0] k);
      logic [1:0] sh;
      unique case (k)
         4'd0, 4'd2, 4'd6, 4'd8: sh = 2'd0;
         4'd1, 4'd3, 4'd5, 4'd7: sh = 2'd1;
         4'd4:                   sh = 2'd2;
         default:                sh = 2'd0;
      endcase
      return sh;
   endfunction

   // ceil(2^32 / d): exact floor division for dividends below 2^28
   function automatic logic [RECIP_W-1:0] recip(input wsum_type d);
      logic [RECIP_W-1:0] r;
      unique case (d)
         5'd4:    r = 31'd1073741824;
         5'd5:    r = 31'd858993460;
         5'd6:    r = 31'd715827883;
         5'd7:    r = 31'd613566757;
         5'd8:    r = 31'd536870912;
         5'd9:    r = 31'd477218589;
         5'd10:   r = 31'd429496730;
         5'd11:   r = 31'd390451573;
         5'd12:   r = 31'd357913942;
         5'd13:   r = 31'd330382100;
         5'd14:   r = 31'd306783379;
         5'd15:   r = 31'd286331154;
         5'd16:   r = 31'd268435456;
         default: r = 31'd0;
      endcase
      return r;
   endfunction

endpackage

// ----- hdl/mgs_ram.sv -----
module mgs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register one read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/mgs_div.sv -----
module mgs_div (
   input  logic                clock,
   input  logic                reset,
   input  mgs_pkg::div_req_type req,
   output mgs_pkg::div_rsp_type rsp
);

   import mgs_pkg::*;

   logic              v1_ff, v2_ff;
   logic              neg_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [SUM_W-1:0]  mag;
   logic [QUOT_W-1:0] qmag;
   height_type        quot_ff, quot_in;

   // Stage 1: magnitude times reciprocal of the weight total
   always_comb begin
      mag     = req.sum[SUM_W-1] ? SUM_W'(-req.sum) : SUM_W'(req.sum);
      prod_in = PROD_W'(mag) * PROD_W'(recip(req.wsum));
   end

   // Stage 2: drop the fraction, restore the sign (truncates toward zero)
   always_comb begin
      qmag    = prod_ff[RECIP_SHIFT +: QUOT_W];
      quot_in = neg_ff ? HEIGHT_W'(-qmag) : HEIGHT_W'(qmag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= req.start;
         v2_ff <= v1_ff;
      end
      prod_ff <= prod_in;
      neg_ff  <= req.sum[SUM_W-1];
      quot_ff <= quot_in;
   end

   // neg_ff is captured on the same edge as prod_ff
   assign rsp.valid = v2_ff;
   assign rsp.quot  = quot_ff;

endmodule

// ----- hdl/masked_gaussian_height_smoother.sv -----
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_height, req_is_triangulated
// rsp       out        rsp_valid / rsp_stall  rsp_smoothed_height, rsp_tile_done
//
// An item is accepted only in the idle state; the next waits until the results it
// releases are handed off. A border, zero or untriangulated result needs the center
// read and the check; a smoothed one also reads nine taps through the single read port
// of the ring RAM, then two divide stages. The last item of a tile releases GRID_SIDE+2
// results in one run. Reset is synchronous; the ring RAM needs no clearing pass.
// A stalled result is held in the output register while the next one is built.
`include "masked_gaussian_height_smoother_macros.svh"

module masked_gaussian_height_smoother (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  mgs_pkg::height_type req_height,
   input  logic                req_is_triangulated,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mgs_pkg::height_type rsp_smoothed_height,
   output logic                rsp_tile_done
);

   import mgs_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CTR    = 3'd1;
   localparam logic [2:0] S_CHK    = 3'd2;
   localparam logic [2:0] S_NBR    = 3'd3;
   localparam logic [2:0] S_DSTART = 3'd4;
   localparam logic [2:0] S_DWAIT  = 3'd5;
   localparam logic [2:0] S_OUT    = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [POS_W-1:0]   in_pos_ff, in_pos_in;
   logic [RA_W-1:0]    wptr_ff, wptr_in;
   logic [POS_W-1:0]   out_pos_ff, out_pos_in;
   logic [RA_W-1:0]    optr_ff, optr_in;
   logic [COORD_W-1:0] out_col_ff, out_col_in;
   logic [COORD_W-1:0] out_row_ff, out_row_in;
   logic               flush_ff, flush_in;
   logic [TAP_W-1:0]   tap_ff, tap_in;
   sum_type            sum_ff, sum_in;
   wsum_type           wsum_ff, wsum_in;
   height_type         res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   height_type         rsp_height_ff;
   logic               rsp_done_ff;

   logic               accept, in_last, out_last, load, interior;
   logic [TAP_W-1:0]   rd_tap;
   logic [RA_W:0]      tap_sum;
   logic [RA_W-1:0]    rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   height_type         rd_height;
   logic               rd_mark;
   sum_type            term;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   // Ring of recent vertices: {mark, height}
   mgs_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(RING_DEPTH)
   ) u_ring (
      .clock  (clock),
      .wr_en  (accept),
      .wr_addr(wptr_ff),
      .wr_data({req_is_triangulated, req_height}),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   mgs_div u_div (
      .clock(clock),
      .reset(reset),
      .req  (div_req),
      .rsp  (div_rsp)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign in_last   = (in_pos_ff == POS_W'(TILE_COUNT - 1));
   assign out_last  = (out_pos_ff == POS_W'(TILE_COUNT - 1));
   assign load      = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign interior  = (out_row_ff != '0) && (out_row_ff != COORD_W'(GRID_SIDE - 1)) &&
                      (out_col_ff != '0) && (out_col_ff != COORD_W'(GRID_SIDE - 1));

   assign rd_height = rd_data[HEIGHT_W-1:0];
   assign rd_mark   = rd_data[HEIGHT_W];

   // Select the ring entry to read: center, then the nine taps
   always_comb begin
      rd_tap  = (state_ff == S_NBR) ? TAP_W'(tap_ff + TAP_W'(1)) : TAP_FIRST;
      tap_sum = (RA_W + 1)'(optr_ff) + (RA_W + 1)'(tap_offset(rd_tap));
      if (state_ff == S_CTR) begin
         rd_addr = optr_ff;
      end else if (tap_sum >= (RA_W + 1)'(RING_DEPTH)) begin
         rd_addr = RA_W'(tap_sum - (RA_W + 1)'(RING_DEPTH));
      end else begin
         rd_addr = RA_W'(tap_sum);
      end
   end

   // Weighted tap, dropped when it holds no data
   assign term = SUM_W'(rd_height) <<< tap_shift(tap_ff);

   assign div_req.start = (state_ff == S_DSTART);
   assign div_req.sum   = sum_ff;
   assign div_req.wsum  = wsum_ff;

   // Sequence the input positions
   always_comb begin
      in_pos_in = in_pos_ff;
      wptr_in   = wptr_ff;
      if (accept) begin
         if (in_last) begin
            in_pos_in = '0;
            wptr_in   = '0;
         end else begin
            in_pos_in = POS_W'(in_pos_ff + POS_W'(1));
            wptr_in   = (wptr_ff == RA_W'(RING_DEPTH - 1)) ? '0 : RA_W'(wptr_ff + RA_W'(1));
         end
      end
   end

   // Main sequencer: gather, divide, hand off
   always_comb begin
      state_in   = state_ff;
      flush_in   = flush_ff;
      tap_in     = tap_ff;
      sum_in     = sum_ff;
      wsum_in    = wsum_ff;
      res_in     = res_ff;
      out_pos_in = out_pos_ff;
      optr_in    = optr_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (in_last || in_pos_ff >= POS_W'(GRID_SIDE + 1))) begin
               state_in = S_CTR;
               flush_in = in_last;
            end
         end
         S_CTR: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            res_in = rd_height;
            if (interior && rd_height != '0 && rd_mark) begin
               tap_in   = TAP_FIRST;
               sum_in   = '0;
               wsum_in  = '0;
               state_in = S_NBR;
            end else begin
               state_in = S_OUT;
            end
         end
         S_NBR: begin
            if (rd_height != '0) begin
               sum_in  = sum_ff + term;
               wsum_in = wsum_ff + (WSUM_W'(1) << tap_shift(tap_ff));
            end
            tap_in = TAP_W'(tap_ff + TAP_W'(1));
            if (tap_ff == TAP_LAST) begin
               state_in = S_DSTART;
            end
         end
         S_DSTART: begin
            state_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (div_rsp.valid) begin
               res_in   = div_rsp.quot;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (load) begin
               if (out_last) begin
                  out_pos_in = '0;
                  optr_in    = '0;
                  out_col_in = '0;
                  out_row_in = '0;
                  state_in   = S_IDLE;
               end else begin
                  out_pos_in = POS_W'(out_pos_ff + POS_W'(1));
                  optr_in    = (optr_ff == RA_W'(RING_DEPTH - 1)) ? '0 :
                               RA_W'(optr_ff + RA_W'(1));
                  if (out_col_ff == COORD_W'(GRID_SIDE - 1)) begin
                     out_col_in = '0;
                     out_row_in = COORD_W'(out_row_ff + COORD_W'(1));
                  end else begin
                     out_col_in = COORD_W'(out_col_ff + COORD_W'(1));
                  end
                  state_in = flush_ff ? S_CTR : S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold a stalled result, load the next one when the slot frees
   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_pos_ff    <= '0;
         wptr_ff      <= '0;
         out_pos_ff   <= '0;
         optr_ff      <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_pos_ff    <= in_pos_in;
         wptr_ff      <= wptr_in;
         out_pos_ff   <= out_pos_in;
         optr_ff      <= optr_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tap_ff  <= tap_in;
      sum_ff  <= sum_in;
      wsum_ff <= wsum_in;
      res_ff  <= res_in;
      if (load) begin
         rsp_height_ff <= res_ff;
         rsp_done_ff   <= out_last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_smoothed_height = rsp_height_ff;
   assign rsp_tile_done       = rsp_done_ff;

   `MGS_CHECK_NOW(a_div_only_waiting, clock, reset, div_rsp.valid, state_ff == S_DWAIT, "divider result outside wait")
   `MGS_CHECK_NOW(a_weight_total, clock, reset, div_req.start, wsum_ff >= WSUM_W'(4) && wsum_ff <= WSUM_W'(16), "weight total out of range")
   `MGS_CHECK_NEXT(a_tile_wrap, clock, reset, load && out_last, out_pos_ff == '0 && in_pos_ff == '0 && state_ff == S_IDLE, "tile end did not rewind counters")

endmodule

// ----- tb/mgs_smoothing_checker.sv -----
module mgs_smoothing_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  mgs_pkg::height_type req_height,
   input  logic                req_is_triangulated,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  mgs_pkg::height_type rsp_smoothed_height,
   input  logic                rsp_tile_done,
   output int                  mismatch_count,
   output int                  outstanding_results,
   output int                  results_checked,
   output int                  filtered_results,
   output int                  tiles_closed
);
   timeunit 1ns;
   timeprecision 1ps;

   import mgs_pkg::*;

   typedef struct packed {
      height_type height;
      logic       tile_done;
   } smoothed_vertex_type;

   // Heights and marks of the tile being streamed, by linear position
   height_type tile_height [TILE_COUNT];
   logic       tile_mark   [TILE_COUNT];

   int next_in_pos  = 0;
   int next_out_pos = 0;
   int errors       = 0;
   int checked      = 0;
   int filtered     = 0;
   int closed       = 0;

   smoothed_vertex_type expected_vertices [$];

   // Work out the result for vertex p and queue it
   function automatic void predict_vertex(input int p);
      int         row;
      int         col;
      int         dy;
      int         dx;
      int         weight;
      int         weight_total;
      longint     acc;
      height_type z;
      height_type value;
      row = p / GRID_SIDE;
      col = p % GRID_SIDE;
      value = tile_height[p];
      if (row > 0 && row < GRID_SIDE - 1 && col > 0 && col < GRID_SIDE - 1 &&
          tile_height[p] != 0 && tile_mark[p]) begin
         acc = 0;
         weight_total = 0;
         for (dy = -1; dy <= 1; dy++) begin
            for (dx = -1; dx <= 1; dx++) begin
               z = tile_height[(row + dy) * GRID_SIDE + col + dx];
               weight = (dy == 0 ? 2 : 1) * (dx == 0 ? 2 : 1);
               // Skip neighbors with no data in both sum and divisor
               if (z != 0) begin
                  acc += longint'(z) * weight;
                  weight_total += weight;
               end
            end
         end
         value = height_type'(acc / weight_total);
         filtered++;
      end
      expected_vertices.push_back('{height: value, tile_done: (p == TILE_COUNT - 1)});
   endfunction

   always @(posedge clock) begin : watch
      smoothed_vertex_type want;
      if (!reset) begin
         // Record the accepted vertex and release the results now due
         if (req_valid && !req_stall) begin
            tile_height[next_in_pos] = req_height;
            tile_mark[next_in_pos] = req_is_triangulated;
            if (next_in_pos >= GRID_SIDE + 1) begin
               predict_vertex(next_out_pos);
               next_out_pos++;
            end
            if (next_in_pos == TILE_COUNT - 1) begin
               // Last vertex flushes the rest of the tile
               while (next_out_pos < TILE_COUNT) begin
                  predict_vertex(next_out_pos);
                  next_out_pos++;
               end
               next_in_pos = 0;
               next_out_pos = 0;
            end else begin
               next_in_pos++;
            end
         end

         // Compare the accepted result with the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (expected_vertices.size() == 0) begin
               $error("unexpected result: smoothed_height %0d tile_done %0b",
                      rsp_smoothed_height, rsp_tile_done);
               errors++;
            end else begin
               want = expected_vertices.pop_front();
               checked++;
               if (rsp_smoothed_height !== want.height) begin
                  $error("smoothed_height: expected %0d, got %0d",
                         want.height, rsp_smoothed_height);
                  errors++;
               end
               if (rsp_tile_done !== want.tile_done) begin
                  $error("tile_done: expected %0b, got %0b", want.tile_done, rsp_tile_done);
                  errors++;
               end
               if (want.tile_done) begin
                  closed++;
               end
            end
         end
      end

      mismatch_count      <= errors;
      outstanding_results <= expected_vertices.size();
      results_checked     <= checked;
      filtered_results    <= filtered;
      tiles_closed        <= closed;
   end

endmodule

// ----- tb/tb_masked_gaussian_height_smoother.sv -----
module tb_masked_gaussian_height_smoother;
   timeunit 1ns;
   timeprecision 1ps;

   import mgs_pkg::*;

   typedef enum int {TILE_DIRECTED, TILE_WIDE, TILE_SPARSE} tile_style_type;
   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_type;

   localparam int         ITEM_COUNT   = 330;
   localparam int         DRAIN_CYCLES = 60;
   localparam height_type HEIGHT_MAX  = 24'sh7FFFFF;
   localparam height_type HEIGHT_MIN  = 24'sh800000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   height_type req_height = '0;
   logic       req_is_triangulated = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   height_type rsp_smoothed_height;
   logic       rsp_tile_done;

   logic           receiver_quiet = 1'b0;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_hold = 0;
   int             stall_phase = 0;

   int mismatch_count;
   int outstanding_results;
   int results_checked;
   int filtered_results;
   int tiles_closed;
   int items_sent = 0;

   // Tile contents to stream, by linear position
   height_type vert_height [TILE_COUNT];
   logic       vert_mark   [TILE_COUNT];

   masked_gaussian_height_smoother uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_height          (req_height),
      .req_is_triangulated (req_is_triangulated),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_smoothed_height (rsp_smoothed_height),
      .rsp_tile_done       (rsp_tile_done)
   );

   mgs_smoothing_checker smoothing_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_height          (req_height),
      .req_is_triangulated (req_is_triangulated),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_smoothed_height (rsp_smoothed_height),
      .rsp_tile_done       (rsp_tile_done),
      .mismatch_count      (mismatch_count),
      .outstanding_results (outstanding_results),
      .results_checked     (results_checked),
      .filtered_results    (filtered_results),
      .tiles_closed        (tiles_closed)
   );

   always #5 clock = ~clock;

   // Set a 3x3 neighborhood: center, side neighbors and corners
   task automatic plant_window(input int row, input int col, input height_type centre_h,
                               input height_type side_h, input height_type corner_h,
                               input logic mark);
      int dy;
      int dx;
      int p;
      for (dy = -1; dy <= 1; dy++) begin
         for (dx = -1; dx <= 1; dx++) begin
            p = (row + dy) * GRID_SIDE + col + dx;
            if (dy == 0 && dx == 0) begin
               vert_height[p] = centre_h;
               vert_mark[p] = mark;
            end else if (dy == 0 || dx == 0) begin
               vert_height[p] = side_h;
            end else begin
               vert_height[p] = corner_h;
            end
         end
      end
   endtask

   task automatic fill_tile(input tile_style_type style);
      int p;
      for (p = 0; p < TILE_COUNT; p++) begin
         if (style == TILE_SPARSE) begin
            // Small heights, half of them missing
            vert_height[p] = ($urandom_range(1) == 0) ? '0 :
                             height_type'(int'($urandom_range(600)) - 300);
            vert_mark[p] = ($urandom_range(3) != 0);
         end else begin
            vert_height[p] = ($urandom_range(3) == 0) ? '0 : height_type'($urandom);
            vert_mark[p] = ($urandom_range(4) != 0);
         end
      end
      if (style == TILE_DIRECTED) begin
         // Border vertices, some at the field extremes, pass through untouched
         vert_height[0] = HEIGHT_MAX;
         vert_height[1] = HEIGHT_MIN;
         vert_height[2] = '0;
         vert_height[3] = height_type'(1);
         vert_height[4] = height_type'(-1);
         vert_mark[0] = 1'b1;
         vert_mark[1] = 1'b1;
         vert_mark[2] = 1'b1;
         vert_mark[3] = 1'b0;
         vert_mark[4] = 1'b1;
         // All neighbors at the positive and negative extremes
         plant_window(2, 2, HEIGHT_MAX, HEIGHT_MAX, HEIGHT_MAX, 1'b1);
         plant_window(2, 6, HEIGHT_MIN, HEIGHT_MIN, HEIGHT_MIN, 1'b1);
         // Lone center among missing neighbors
         plant_window(2, 10, height_type'(5), '0, '0, 1'b1);
         // Zero center stays zero even when triangulated
         plant_window(2, 14, '0, height_type'(100), height_type'(100), 1'b1);
         // Untriangulated center passes through
         plant_window(2, 18, height_type'(1000), height_type'(7), height_type'(9), 1'b0);
         // Missing sides drop out; negative mean truncates toward zero
         plant_window(2, 22, height_type'(-7), '0, height_type'(-2), 1'b1);
         // Mixed extremes of both signs
         plant_window(2, 26, HEIGHT_MAX, HEIGHT_MIN, HEIGHT_MAX, 1'b1);
         // Positive means that truncate to zero, and a negative mean that divides exactly
         plant_window(2, 30, height_type'(3), height_type'(-1), '0, 1'b1);
         plant_window(5, 5, height_type'(-1), height_type'(1), height_type'(1), 1'b1);
         plant_window(5, 9, height_type'(-3), '0, height_type'(1), 1'b1);
      end
   endtask

   // Receiver stall pattern: modes of random length
   always @(posedge clock) begin : receiver
      logic stall_next;
      case (stall_mode)
         STALL_RANDOM:   stall_next = ($urandom_range(99) < 35);
         STALL_PERIODIC: stall_next = ((stall_phase % 7) < 3);
         STALL_HEAVY:    stall_next = ($urandom_range(99) < 85);
         default:        stall_next = 1'b0;
      endcase
      rsp_stall <= stall_next && !receiver_quiet;
      stall_phase <= stall_phase + 1;
      if (stall_hold == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(3));
         stall_hold <= $urandom_range(200, 20);
      end else begin
         stall_hold <= stall_hold - 1;
      end
   end

   initial begin : stimulus
      int p;
      int burst_left;
      int gap;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      burst_left = 0;

      fill_tile(TILE_DIRECTED);
      for (p = 0; p < ITEM_COUNT; p++) begin
         // Start a new burst, after a random gap
         if (burst_left == 0) begin
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(300, 100) :
                                                   $urandom_range(40, 1);
            gap = $urandom_range(12);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         req_valid <= 1'b1;
         req_height <= vert_height[p];
         req_is_triangulated <= vert_mark[p];
         // Hold the item until it is taken
         @(posedge clock);
         while (req_stall) @(posedge clock);
         items_sent++;
         burst_left--;
      end
      req_valid <= 1'b0;
      receiver_quiet <= 1'b1;

      // Drain the outstanding results, then watch for strays
      @(posedge clock);
      while (outstanding_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Streamed %0d vertices: the leading rows of one tile with directed windows.",
               items_sent);
      $display("Checked %0d results, %0d of them filtered, %0d tile ends.",
               results_checked, filtered_results, tiles_closed);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #10ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
